// ===== hw/rtl/aip_pkg.sv =====
// shared types, codes and helpers for the ascii integer parser
package aip_pkg;

  localparam int MAX_WIDTH = 64;

  // register indexes
  localparam logic [1:0] REG_RADIX        = 2'd0;
  localparam logic [1:0] REG_WIDTH_SELECT = 2'd1;
  localparam logic [1:0] REG_SIGNED_MODE  = 2'd2;

  // result status codes
  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_BASE  = 3'd1;
  localparam logic [2:0] ST_EMPTY = 3'd2;
  localparam logic [2:0] ST_CHAR  = 3'd3;
  localparam logic [2:0] ST_RANGE = 3'd4;

  // character codes
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LZ    = 8'h7a;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UZ    = 8'h5a;
  localparam logic [7:0] CH_LX    = 8'h78;
  localparam logic [7:0] CH_UX    = 8'h58;
  localparam logic [7:0] CH_LO    = 8'h6f;
  localparam logic [7:0] CH_UO    = 8'h4f;
  localparam logic [7:0] CH_LB    = 8'h62;
  localparam logic [7:0] CH_UB    = 8'h42;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_PLUS  = 8'h2b;

  localparam logic [5:0] RADIX_MAX = 6'd36;
  localparam logic [5:0] RADIX_DEC = 6'd10;
  localparam logic [5:0] RADIX_HEX = 6'd16;
  localparam logic [5:0] RADIX_OCT = 6'd8;
  localparam logic [5:0] RADIX_BIN = 6'd2;

  typedef enum logic [3:0] {
    PH_START  = 4'b0001,
    PH_SIGNED = 4'b0010,
    PH_ZERO   = 4'b0100,
    PH_DIGITS = 4'b1000
  } phase_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] char_code;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [63:0] value;
  } out_word_t;

  typedef struct packed {
    logic [5:0] radix;
    logic [1:0] width_select;
    logic       signed_mode;
  } cfg_t;

  // result width in bits, capped at MAX_WIDTH
  function automatic logic [6:0] width_bits(input logic [1:0] ws);
    logic [7:0] w;
    w = 8'd8 << ws;
    if (w > 8'(MAX_WIDTH)) begin
      w = 8'(MAX_WIDTH);
    end
    return w[6:0];
  endfunction

endpackage

// ===== hw/rtl/ascii_integer_parser.sv =====
// top level of the ascii integer parser
//
//   channel   dir  handshake                 word
//   char      in   char_valid / char_stall   char_word (kind, char_code)
//   result    out  result_valid / result_stall result_word (status, value)
//   cfg       in   cfg_we                    cfg_index, cfg_data
//
// one word accepted per cycle unless char_stall holds it; a character is
// taken into the input register and then updates the state, an end mark's
// result passes from the input register into the result register once that
// register is free; the core's step logic is the combinational 64x6
// multiply-add and compare; reset clears state, configuration and valids;
// a stalled result holds an end mark in the input register while characters behind a delivered result keep flowing
module ascii_integer_parser import aip_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       char_valid,
  output logic       char_stall,
  input  in_word_t   char_word,
  output logic       result_valid,
  input  logic       result_stall,
  output out_word_t  result_word,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [5:0] cfg_data
);

  logic      held_valid;
  in_word_t  held_word;
  logic      out_free;
  logic      advance;
  out_word_t step_result;

  // a character never needs the result register
  assign advance = held_valid && (!held_word.kind || out_free);

  aip_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .char_valid (char_valid),
    .char_stall (char_stall),
    .char_word  (char_word),
    .advance    (advance),
    .held_valid (held_valid),
    .held_word  (held_word)
  );

  aip_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .step      (advance),
    .item      (held_word),
    .result    (step_result)
  );

  aip_out_stage u_out (
    .clk          (clk),
    .rst          (rst),
    .load         (advance && held_word.kind),
    .load_word    (step_result),
    .free         (out_free),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_word  (result_word)
  );

endmodule

// ===== hw/rtl/aip_in_stage.sv =====
// input register: holds one accepted word until the core takes it
module aip_in_stage import aip_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     char_valid,
  output logic     char_stall,
  input  in_word_t char_word,
  input  logic     advance,
  output logic     held_valid,
  output in_word_t held_word
);

  assign char_stall = held_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (!char_stall) begin
      held_valid <= char_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (char_valid && !char_stall) begin
      held_word <= char_word;
    end
  end

endmodule

// ===== hw/rtl/aip_core.sv =====
// parse state, configuration registers and the per-word step logic
module aip_core import aip_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [5:0] cfg_data,
  input  logic       step,
  input  in_word_t   item,
  output out_word_t  result
);

  cfg_t        cfg;
  phase_t      phase, phase_next;
  logic [63:0] acc, acc_next;
  logic        neg, neg_next;
  logic [5:0]  active_radix, active_radix_next;
  logic [2:0]  err, err_next;

  logic        fresh;
  logic [5:0]  ar0;
  logic [2:0]  err0;
  logic [7:0]  c;
  logic        dig_ok;
  logic [5:0]  dig_val;
  logic [5:0]  ar_d;
  logic [5:0]  base;
  logic [6:0]  w;
  logic [70:0] lim_pos;
  logic [70:0] lim_neg;
  logic [70:0] lim;
  logic [69:0] prod;
  logic [70:0] sum;
  logic        is_prefix;
  logic [5:0]  want;
  logic        take;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.radix        <= 6'd0;
      cfg.width_select <= 2'd3;
      cfg.signed_mode  <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RADIX:        cfg.radix        <= cfg_data;
        REG_WIDTH_SELECT: cfg.width_select <= cfg_data[1:0];
        REG_SIGNED_MODE:  cfg.signed_mode  <= cfg_data[0];
        default:          ;
      endcase
    end
  end

  // radix is sampled on the first word of each string
  assign fresh = (phase == PH_START) && (err == ST_OK);
  assign ar0   = fresh ? cfg.radix : active_radix;
  assign err0  = (fresh && (cfg.radix == 6'd1 || cfg.radix > RADIX_MAX)) ? ST_BASE : err;
  assign c     = item.char_code;

  always_comb begin
    dig_ok  = 1'b1;
    dig_val = 6'd0;
    if (c inside {[CH_ZERO:CH_NINE]}) begin
      dig_val = 6'(c - CH_ZERO);
    end else if (c inside {[CH_LA:CH_LZ]}) begin
      dig_val = 6'(c - CH_LA) + 6'd10;
    end else if (c inside {[CH_UA:CH_UZ]}) begin
      dig_val = 6'(c - CH_UA) + 6'd10;
    end else begin
      dig_ok = 1'b0;
    end
  end

  assign ar_d = (ar0 == 6'd0) ? RADIX_DEC : ar0;
  assign base = (ar_d < 6'd2 || ar_d > RADIX_MAX) ? RADIX_DEC : ar_d;

  // range check as acc*base + digit > limit, no divide needed
  assign w       = width_bits(cfg.width_select);
  assign lim_pos = (71'(1) << w) - 71'(1);
  assign lim_neg = 71'(1) << (w - 7'd1);
  assign lim     = neg ? lim_neg : lim_pos;
  assign prod    = {6'd0, acc} * 70'(base);
  assign sum     = 71'(prod) + 71'(dig_val);

  always_comb begin
    is_prefix = 1'b1;
    want      = RADIX_HEX;
    if (c == CH_LX || c == CH_UX) begin
      want = RADIX_HEX;
    end else if (c == CH_LO || c == CH_UO) begin
      want = RADIX_OCT;
    end else if (c == CH_LB || c == CH_UB) begin
      want = RADIX_BIN;
    end else begin
      is_prefix = 1'b0;
    end
  end

  always_comb begin
    phase_next        = phase;
    acc_next          = acc;
    neg_next          = neg;
    active_radix_next = ar0;
    err_next          = err0;
    take              = 1'b0;
    result.status     = err0;
    result.value      = 64'd0;

    if (item.kind) begin
      if (err0 == ST_OK) begin
        if (phase == PH_START || phase == PH_SIGNED) begin
          result.status = ST_EMPTY;
        end else if (neg) begin
          result.value = (64'd0 - acc) & lim_pos[63:0];
        end else begin
          result.value = acc & lim_pos[63:0];
        end
      end
      phase_next        = PH_START;
      acc_next          = 64'd0;
      neg_next          = 1'b0;
      active_radix_next = 6'd0;
      err_next          = ST_OK;
    end else if (err0 == ST_OK) begin
      case (phase)
        PH_START: begin
          if (c == CH_PLUS) begin
            phase_next = PH_SIGNED;
          end else if (c == CH_MINUS && cfg.signed_mode) begin
            neg_next   = 1'b1;
            phase_next = PH_SIGNED;
          end else if (c == CH_ZERO) begin
            phase_next = PH_ZERO;
          end else begin
            take = 1'b1;
          end
        end
        PH_SIGNED: begin
          if (c == CH_ZERO) begin
            phase_next = PH_ZERO;
          end else begin
            take = 1'b1;
          end
        end
        PH_ZERO: begin
          if (is_prefix) begin
            if (ar0 != 6'd0 && ar0 != want) begin
              err_next = ST_CHAR;
            end else begin
              active_radix_next = want;
              phase_next        = PH_DIGITS;
            end
          end else begin
            take = 1'b1;
          end
        end
        default: take = 1'b1;
      endcase

      if (take) begin
        active_radix_next = ar_d;
        phase_next        = PH_DIGITS;
        if (!dig_ok || dig_val >= base) begin
          err_next = ST_CHAR;
        end else if (sum > lim) begin
          err_next = ST_RANGE;
        end else begin
          acc_next = sum[63:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_START;
      acc          <= 64'd0;
      neg          <= 1'b0;
      active_radix <= 6'd0;
      err          <= ST_OK;
    end else if (step) begin
      phase        <= phase_next;
      acc          <= acc_next;
      neg          <= neg_next;
      active_radix <= active_radix_next;
      err          <= err_next;
    end
  end

  // an end mark starts a clean string
  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    step && item.kind |=> phase == PH_START && err == ST_OK && acc == 64'd0)
    else $error("state not cleared after end mark");

  // the first error stays until the end mark
  a_err_sticky: assert property (@(posedge clk) disable iff (rst)
    step && !item.kind && err != ST_OK |=> err == $past(err))
    else $error("latched error changed");

  // a character never produces a nonzero accumulator past the positive limit
  a_acc_in_range: assert property (@(posedge clk) disable iff (rst)
    step && !item.kind && err_next == ST_OK |=> 71'(acc) <= lim_pos || neg)
    else $error("accumulator beyond limit");

endmodule

// ===== hw/rtl/aip_out_stage.sv =====
// result register: holds one result word until it is taken
module aip_out_stage import aip_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      load,
  input  out_word_t load_word,
  output logic      free,
  output logic      result_valid,
  input  logic      result_stall,
  output out_word_t result_word
);

  assign free = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_word <= load_word;
    end
  end

  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    load |-> free)
    else $error("result overwritten while stalled");

  a_error_zero_value: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_word.status != ST_OK |-> result_word.value == 64'd0)
    else $error("error result with nonzero value");

endmodule

// ===== tb/tb.sv =====
// self-checking testbench for the ascii integer parser
`timescale 1ns / 100ps

module tb;
  import aip_pkg::*;

  localparam logic KIND_CHAR = 1'b0;
  localparam logic KIND_END  = 1'b1;
  localparam int   CYCLE_LIMIT = 200000;
  localparam int   RANDOM_WORDS = 520;

  logic       clk = 1'b0;
  logic       rst;
  logic       char_valid;
  logic       char_stall;
  in_word_t   char_word;
  logic       result_valid;
  logic       result_stall = 1'b0;
  out_word_t  result_word;
  logic       cfg_we;
  logic [1:0] cfg_index;
  logic [5:0] cfg_data;

  ascii_integer_parser dut (
    .clk(clk),
    .rst(rst),
    .char_valid(char_valid),
    .char_stall(char_stall),
    .char_word(char_word),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result_word(result_word),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // parser state mirrored from the accepted words
  logic [63:0] acc_q;
  phase_t      phase_q;
  logic        neg_q;
  logic [5:0]  base_q;
  logic [2:0]  err_q;
  logic [5:0]  cfg_radix;
  logic [1:0]  cfg_ws;
  logic        cfg_signed;

  out_word_t   pending_results[$];
  bit          use_typed = 1'b0;
  out_word_t   typed_result;

  int fail_count = 0;
  int words_sent = 0;
  int results_checked = 0;
  int cfg_sets = 0;
  int cycle_cnt = 0;
  bit drv_calm = 1'b0;

  function automatic logic [63:0] width_mask(input logic [1:0] ws);
    case (ws)
      2'd0: return 64'h0000_0000_0000_00ff;
      2'd1: return 64'h0000_0000_0000_ffff;
      2'd2: return 64'h0000_0000_ffff_ffff;
      default: return 64'hffff_ffff_ffff_ffff;
    endcase
  endfunction

  function automatic void clear_string();
    acc_q = '0;
    phase_q = PH_START;
    neg_q = 1'b0;
    base_q = '0;
    err_q = ST_OK;
  endfunction

  function automatic void note_err(input logic [2:0] code);
    if (err_q == ST_OK) begin
      err_q = code;
    end
  endfunction

  function automatic void add_digit(input logic [7:0] c);
    logic [63:0] dv;
    logic [63:0] b;
    logic [63:0] lim;
    logic [63:0] qmax;
    logic [63:0] rmax;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      dv = 64'(c - CH_ZERO);
    end else if (c >= CH_LA && c <= CH_LZ) begin
      dv = 64'(c - CH_LA) + 64'd10;
    end else if (c >= CH_UA && c <= CH_UZ) begin
      dv = 64'(c - CH_UA) + 64'd10;
    end else begin
      note_err(ST_CHAR);
      return;
    end
    b = (base_q < RADIX_BIN || base_q > RADIX_MAX) ? 64'(RADIX_DEC) : 64'(base_q);
    if (dv >= b) begin
      note_err(ST_CHAR);
      return;
    end
    lim = neg_q ? (width_mask(cfg_ws) >> 1) + 64'd1 : width_mask(cfg_ws);
    qmax = lim / b;
    rmax = lim % b;
    if (acc_q > qmax || (acc_q == qmax && dv > rmax)) begin
      note_err(ST_RANGE);
      return;
    end
    acc_q = acc_q * b + dv;
  endfunction

  function automatic void first_digit(input logic [7:0] c);
    if (c == CH_ZERO) begin
      phase_q = PH_ZERO;
    end else begin
      if (base_q == '0) begin
        base_q = RADIX_DEC;
      end
      phase_q = PH_DIGITS;
      add_digit(c);
    end
  endfunction

  function automatic void take_prefix(input logic [5:0] want);
    if (base_q != '0 && base_q != want) begin
      note_err(ST_CHAR);
    end else begin
      base_q = want;
      phase_q = PH_DIGITS;
    end
  endfunction

  function automatic void parse_word(input in_word_t w, output bit got, output out_word_t res);
    logic [7:0] c;
    c = w.char_code;
    got = 1'b0;
    res = '0;
    if (phase_q == PH_START && err_q == ST_OK) begin
      base_q = cfg_radix;
      if (base_q == 6'd1 || base_q > RADIX_MAX) begin
        note_err(ST_BASE);
      end
    end
    if (w.kind == KIND_END) begin
      got = 1'b1;
      res.status = err_q;
      if (err_q == ST_OK) begin
        if (phase_q == PH_START || phase_q == PH_SIGNED) begin
          res.status = ST_EMPTY;
        end else begin
          res.value = (neg_q ? -acc_q : acc_q) & width_mask(cfg_ws);
        end
      end
      clear_string();
      return;
    end
    if (err_q != ST_OK) begin
      return;
    end
    case (phase_q)
      PH_START: begin
        if (c == CH_PLUS) begin
          phase_q = PH_SIGNED;
        end else if (c == CH_MINUS && cfg_signed) begin
          neg_q = 1'b1;
          phase_q = PH_SIGNED;
        end else begin
          first_digit(c);
        end
      end
      PH_SIGNED: first_digit(c);
      PH_ZERO: begin
        if (c == CH_LX || c == CH_UX) begin
          take_prefix(RADIX_HEX);
        end else if (c == CH_LO || c == CH_UO) begin
          take_prefix(RADIX_OCT);
        end else if (c == CH_LB || c == CH_UB) begin
          take_prefix(RADIX_BIN);
        end else begin
          if (base_q == '0) begin
            base_q = RADIX_DEC;
          end
          phase_q = PH_DIGITS;
          add_digit(c);
        end
      end
      default: add_digit(c);
    endcase
  endfunction

  // track accepted words and check delivered results
  always @(posedge clk) begin
    bit        got;
    out_word_t res;
    out_word_t want;
    if (rst) begin
      clear_string();
      cfg_radix = '0;
      cfg_ws = 2'd3;
      cfg_signed = 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_RADIX:        cfg_radix = cfg_data;
          REG_WIDTH_SELECT: cfg_ws = cfg_data[1:0];
          REG_SIGNED_MODE:  cfg_signed = cfg_data[0];
          default: ;
        endcase
      end
      if (char_valid && !char_stall) begin
        parse_word(char_word, got, res);
        if (got) begin
          pending_results.push_back(use_typed ? typed_result : res);
        end
      end
      if (result_valid && !result_stall) begin
        if (pending_results.size() == 0) begin
          $error("unexpected result word: status %0d value %h",
                 result_word.status, result_word.value);
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          results_checked++;
          if (result_word.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, result_word.status);
            fail_count++;
          end
          if (result_word.value !== want.value) begin
            $error("value: expected %h, got %h", want.value, result_word.value);
            fail_count++;
          end
        end
      end
    end
  end

  // receiver: random stalls, one long hold-off, a calm stretch
  int  taken_cnt = 0;
  int  hold_left = 0;
  bit  hold_done = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        taken_cnt <= taken_cnt + 1;
      end
      if (hold_left != 0) begin
        result_stall <= 1'b1;
        hold_left <= hold_left - 1;
      end else if (!hold_done && taken_cnt == 30) begin
        hold_done <= 1'b1;
        hold_left <= 400;
        result_stall <= 1'b1;
      end else if (taken_cnt >= 50 && taken_cnt < 75) begin
        result_stall <= 1'b0;
      end else begin
        result_stall <= ($urandom_range(99) < 11);
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic send_word(input logic k, input logic [7:0] c);
    if (!drv_calm && $urandom_range(99) < 11) begin
      char_valid <= 1'b0;
      @(posedge clk);
    end
    char_valid <= 1'b1;
    char_word <= '{kind: k, char_code: c};
    do @(posedge clk); while (char_stall);
    words_sent++;
  endtask

  task automatic wait_idle();
    char_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_config(input logic [5:0] r, input logic [1:0] ws, input logic s);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_index <= REG_RADIX;
    cfg_data <= r;
    @(posedge clk);
    cfg_index <= REG_WIDTH_SELECT;
    cfg_data <= {4'd0, ws};
    @(posedge clk);
    cfg_index <= REG_SIGNED_MODE;
    cfg_data <= {5'd0, s};
    @(posedge clk);
    cfg_we <= 1'b0;
    cfg_sets++;
  endtask

  logic [7:0] str_q[$];

  task automatic send_string();
    foreach (str_q[i]) begin
      send_word(KIND_CHAR, str_q[i]);
    end
    send_word(KIND_END, 8'($urandom_range(255)));
  endtask

  function automatic logic [7:0] digit_char(input int dv);
    if (dv < 10) begin
      return CH_ZERO + 8'(dv);
    end
    return ($urandom_range(1) ? CH_LA : CH_UA) + 8'(dv - 10);
  endfunction

  // mostly well-formed numbers, some with one corrupted word, some pure noise
  task automatic build_string(input logic [5:0] r);
    int     pick;
    int     sel;
    int     eff;
    int     ndig;
    logic   upper;
    pick = $urandom_range(99);
    str_q.delete();
    sel = $urandom_range(3);
    if (sel == 0) begin
      str_q.push_back(CH_PLUS);
    end else if (sel == 1) begin
      str_q.push_back(CH_MINUS);
    end
    eff = (r >= RADIX_BIN && r <= RADIX_MAX) ? int'(r) : int'(RADIX_DEC);
    sel = $urandom_range(3);
    upper = 1'($urandom_range(1));
    if ((r == '0 || r == RADIX_HEX || r == RADIX_OCT || r == RADIX_BIN) && sel != 0) begin
      if (r != '0) begin
        sel = (r == RADIX_HEX) ? 1 : (r == RADIX_OCT) ? 2 : 3;
      end
      str_q.push_back(CH_ZERO);
      case (sel)
        1: begin str_q.push_back(upper ? CH_UX : CH_LX); eff = int'(RADIX_HEX); end
        2: begin str_q.push_back(upper ? CH_UO : CH_LO); eff = int'(RADIX_OCT); end
        default: begin str_q.push_back(upper ? CH_UB : CH_LB); eff = int'(RADIX_BIN); end
      endcase
    end
    ndig = ($urandom_range(9) == 0) ? $urandom_range(1, 70) : $urandom_range(0, 8);
    repeat (ndig) str_q.push_back(digit_char($urandom_range(eff - 1)));
    if (pick >= 75 && pick < 90) begin
      if (str_q.size() == 0) begin
        str_q.push_back(8'($urandom_range(255)));
      end else if ($urandom_range(1)) begin
        str_q[$urandom_range(str_q.size() - 1)] = 8'($urandom_range(255));
      end else begin
        str_q.insert($urandom_range(str_q.size()), $urandom_range(1) ? CH_MINUS : CH_PLUS);
      end
    end else if (pick >= 90) begin
      str_q.delete();
      repeat ($urandom_range(0, 6)) str_q.push_back(8'($urandom_range(255)));
    end
  endtask

  function automatic logic [5:0] pick_radix();
    case ($urandom_range(9))
      0, 1, 2: return 6'd0;
      3: return RADIX_BIN;
      4: return RADIX_OCT;
      5: return RADIX_HEX;
      6: return RADIX_MAX;
      7: return RADIX_DEC;
      8: return ($urandom_range(1) ? 6'd63 : ($urandom_range(1) ? 6'd1 : 6'd37));
      default: return 6'($urandom_range(2, 36));
    endcase
  endfunction

  typedef struct {
    logic [159:0] text;
    int           len;
    logic [5:0]   radix;
    logic [1:0]   ws;
    logic         sgn;
    bit           typed;
    logic [2:0]   status;
    logic [63:0]  value;
  } dir_row_t;

  dir_row_t dir_tab [18];

  initial begin
    logic [5:0] cur_radix;
    int         strings_done;
    int         rand_start;

    rst = 1'b1;
    char_valid = 1'b0;
    char_word = '0;
    cfg_we = 1'b0;
    cfg_index = REG_RADIX;
    cfg_data = '0;

    //          text                    len radix ws sgn typed status    value
    dir_tab = '{
      '{"",                      0,  0, 3, 0, 1, ST_EMPTY, 64'd0},
      '{"+",                     1,  0, 3, 0, 1, ST_EMPTY, 64'd0},
      '{"0",                     1,  0, 3, 0, 1, ST_OK,    64'd0},
      '{"0X",                    2,  0, 3, 0, 1, ST_OK,    64'd0},
      '{"0x1",                   3,  8, 3, 0, 1, ST_CHAR,  64'd0},
      '{"255",                   3, 10, 0, 0, 1, ST_OK,    64'd255},
      '{"256",                   3, 10, 0, 0, 1, ST_RANGE, 64'd0},
      '{"-128",                  4,  0, 0, 1, 1, ST_OK,    64'h80},
      '{"-129",                  4,  0, 0, 1, 1, ST_RANGE, 64'd0},
      '{"-5",                    2,  0, 0, 0, 1, ST_CHAR,  64'd0},
      '{"+-1",                   3,  0, 3, 1, 1, ST_CHAR,  64'd0},
      '{"zZ",                    2, 36, 1, 0, 0, ST_OK,    64'd0},
      '{"7",                     1,  1, 3, 0, 1, ST_BASE,  64'd0},
      '{"",                      0, 63, 3, 0, 1, ST_BASE,  64'd0},
      '{{"1", 8'h00},            2,  0, 3, 0, 1, ST_CHAR,  64'd0},
      '{160'hff,                 1,  0, 3, 0, 1, ST_CHAR,  64'd0},
      '{"0xFFFFFFFFFFFFFFFF",   18,  0, 3, 0, 1, ST_OK,    64'hffff_ffff_ffff_ffff},
      '{"007",                   3,  0, 2, 0, 0, ST_OK,    64'd0}
    };

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_tab[i]) begin
      set_config(dir_tab[i].radix, dir_tab[i].ws, dir_tab[i].sgn);
      use_typed = dir_tab[i].typed;
      typed_result = '{status: dir_tab[i].status, value: dir_tab[i].value};
      str_q.delete();
      for (int k = dir_tab[i].len - 1; k >= 0; k--) begin
        str_q.push_back(dir_tab[i].text[8*k +: 8]);
      end
      send_string();
    end
    wait_idle();
    use_typed = 1'b0;

    // random strings, new register setting every dozen strings
    strings_done = 0;
    rand_start = words_sent;
    cur_radix = '0;
    while (words_sent - rand_start < RANDOM_WORDS) begin
      if (strings_done % 12 == 0) begin
        cur_radix = pick_radix();
        set_config(cur_radix, 2'($urandom_range(3)), 1'($urandom_range(1)));
      end
      drv_calm = (words_sent - rand_start >= 250 && words_sent - rand_start < 400);
      build_string(cur_radix);
      send_string();
      strings_done++;
    end

    char_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
    repeat (10) @(posedge clk);
    $display("sent %0d words in %0d random and %0d directed strings", words_sent,
             strings_done, $size(dir_tab));
    $display("checked %0d results over %0d register settings", results_checked, cfg_sets);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
